/* src/aac_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aac_pkg
// Shared constants, register indexes, types and the exponential table of the
// annealing acceptance controller.
// ----------------------------------------------------------------------------
package aac_pkg;

  // Fixed field widths.
  localparam int TEMP_W     = 32;
  localparam int FRAC_W     = 16;
  localparam int COOL_W     = 16;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int PROB_W     = 17;

  // Parameter defaults.
  localparam int DEF_ENERGY_WIDTH    = 32;
  localparam int DEF_TAG_WIDTH       = 16;
  localparam int DEF_EXP_TABLE_DEPTH = 256;

  // Largest table depth that the constant table covers.
  localparam int EXP_MAX_DEPTH = 1024;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_START_TEMP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END_TEMP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COOLING    = 2'd2;

  // Register reset values.
  localparam logic [TEMP_W-1:0] RST_START_TEMP = 32'd65536000;
  localparam logic [TEMP_W-1:0] RST_END_TEMP   = 32'd1;
  localparam logic [COOL_W-1:0] RST_COOLING    = 16'd65208;

  // exp(-1/16) in Q0.32.
  localparam logic [63:0] EXP_STEP_Q32 = 64'd4034748382;

  typedef struct packed {
    logic [TEMP_W-1:0] start_temp;
    logic [TEMP_W-1:0] end_temp;
    logic [COOL_W-1:0] cooling;
  } cfg_t;

  // Result handoff from the sequencer to the output register.
  typedef struct packed {
    logic load;
    logic accepted;
    logic done;
  } res_flags_t;

  typedef logic [PROB_W-1:0] exp_rom_t [EXP_MAX_DEPTH];

  // Entry k holds exp(-k/16) in Q1.16, built from a rounded Q0.32 product chain.
  function automatic exp_rom_t build_exp_rom();
    exp_rom_t    rom;
    logic [63:0] v;
    v = 64'h1_0000_0000;
    for (int k = 0; k < EXP_MAX_DEPTH; k++) begin
      if (k > 0) begin
        v = (v * EXP_STEP_Q32 + 64'h8000_0000) >> 32;
      end
      rom[k] = PROB_W'((v + 64'd32768) >> 16);
    end
    return rom;
  endfunction

endpackage

/* src/aac_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aac_if
// Valid/ready channels of the annealing acceptance controller: proposal beats
// in, result beats out.
// ----------------------------------------------------------------------------
interface aac_proposal_if #(
  parameter int ENERGY_WIDTH = aac_pkg::DEF_ENERGY_WIDTH,
  parameter int TAG_WIDTH    = aac_pkg::DEF_TAG_WIDTH
);
  import aac_pkg::*;

  logic                           valid;
  logic                           ready;
  logic                           kind;
  logic [TAG_WIDTH-1:0]           candidate_tag;
  logic signed [ENERGY_WIDTH-1:0] candidate_energy;
  logic [FRAC_W-1:0]              random_fraction;

  modport source (
    output valid, kind, candidate_tag, candidate_energy, random_fraction,
    input  ready
  );
  modport sink (
    input  valid, kind, candidate_tag, candidate_energy, random_fraction,
    output ready
  );
endinterface

interface aac_result_if #(
  parameter int ENERGY_WIDTH = aac_pkg::DEF_ENERGY_WIDTH,
  parameter int TAG_WIDTH    = aac_pkg::DEF_TAG_WIDTH
);
  import aac_pkg::*;

  logic                           valid;
  logic                           ready;
  logic                           accepted;
  logic                           done_res;
  logic signed [ENERGY_WIDTH-1:0] best_energy_out;
  logic [TAG_WIDTH-1:0]           best_tag_out;
  logic signed [ENERGY_WIDTH-1:0] current_energy_out;
  logic [TEMP_W-1:0]              temperature_out;

  modport source (
    output valid, accepted, done_res, best_energy_out, best_tag_out,
           current_energy_out, temperature_out,
    input  ready
  );
  modport sink (
    input  valid, accepted, done_res, best_energy_out, best_tag_out,
           current_energy_out, temperature_out,
    output ready
  );
endinterface

/* src/annealing_acceptance_controller_top.sv */
`timescale 1ns / 1ps
// Sequencing: a start beat runs the start, finish-check and finish states; an
// ignored proposal (block finished) goes straight to finish; a proposal accepted
// outright runs compare, best update, cooling, finish check and finish; a rise in
// energy adds the restoring division, table lookup and decision. The finish state
// waits for a free output register and loads the result before a new beat is taken.
// Reset: synchronous; registers return to their defaults and the block is finished.
// ----------------------------------------------------------------------------
// annealing_acceptance_controller_top
// Metropolis acceptance and geometric cooling controller with configuration
// registers and a registered result channel.
// ----------------------------------------------------------------------------
module annealing_acceptance_controller_top #(
  parameter int ENERGY_WIDTH    = aac_pkg::DEF_ENERGY_WIDTH,
  parameter int TAG_WIDTH       = aac_pkg::DEF_TAG_WIDTH,
  parameter int EXP_TABLE_DEPTH = aac_pkg::DEF_EXP_TABLE_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [aac_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [aac_pkg::CFG_DATA_W-1:0]   cfg_data,
  aac_proposal_if.sink                     proposal,
  aac_result_if.source                     result
);
  import aac_pkg::*;

  cfg_t                           cfg;
  logic                           core_idle;
  logic                           out_free;
  res_flags_t                     res;
  logic signed [ENERGY_WIDTH-1:0] core_best_e;
  logic [TAG_WIDTH-1:0]           core_best_tag;
  logic signed [ENERGY_WIDTH-1:0] core_cur_e;
  logic [TEMP_W-1:0]              core_temperature;
  logic                           out_valid;

  // Configuration registers; writes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_temp <= RST_START_TEMP;
      cfg.end_temp   <= RST_END_TEMP;
      cfg.cooling    <= RST_COOLING;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_START_TEMP: cfg.start_temp <= cfg_data[TEMP_W-1:0];
        REG_END_TEMP:   cfg.end_temp   <= cfg_data[TEMP_W-1:0];
        REG_COOLING:    cfg.cooling    <= cfg_data[COOL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign proposal.ready = core_idle;

  aac_core #(
    .ENERGY_WIDTH    (ENERGY_WIDTH),
    .TAG_WIDTH       (TAG_WIDTH),
    .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .start       (proposal.valid && core_idle),
    .kind        (proposal.kind),
    .tag         (proposal.candidate_tag),
    .energy      (proposal.candidate_energy),
    .rnd         (proposal.random_fraction),
    .out_free    (out_free),
    .idle        (core_idle),
    .res         (res),
    .best_e      (core_best_e),
    .best_tag    (core_best_tag),
    .cur_e       (core_cur_e),
    .temperature (core_temperature)
  );

  // Result register: free when empty or when its beat leaves this cycle.
  assign out_free = !out_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.load) begin
      result.accepted           <= res.accepted;
      result.done_res           <= res.done;
      result.best_energy_out    <= core_best_e;
      result.best_tag_out       <= core_best_tag;
      result.current_energy_out <= core_cur_e;
      result.temperature_out    <= core_temperature;
    end
  end

  assign result.valid = out_valid;

endmodule

/* src/aac_sub.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aac_sub
// Shared subtractor: difference and borrow, used for every energy compare,
// every division step and the end-temperature check.
// ----------------------------------------------------------------------------
module aac_sub #(
  parameter int W = 48
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic [W-1:0] diff,
  output logic         borrow
);
  // Borrow is set when a is below b as unsigned values.
  assign {borrow, diff} = {1'b0, a} - {1'b0, b};
endmodule

/* src/aac_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aac_core
// Sequencer and state of the annealing controller. One subtractor is stepped
// through compare, restoring division, best update and finish check; the
// cooling multiply has a step of its own.
// ----------------------------------------------------------------------------
module aac_core #(
  parameter int ENERGY_WIDTH    = aac_pkg::DEF_ENERGY_WIDTH,
  parameter int TAG_WIDTH       = aac_pkg::DEF_TAG_WIDTH,
  parameter int EXP_TABLE_DEPTH = aac_pkg::DEF_EXP_TABLE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  aac_pkg::cfg_t                  cfg,
  input  logic                           start,
  input  logic                           kind,
  input  logic [TAG_WIDTH-1:0]           tag,
  input  logic [ENERGY_WIDTH-1:0]        energy,
  input  logic [aac_pkg::FRAC_W-1:0]     rnd,
  input  logic                           out_free,
  output logic                           idle,
  output aac_pkg::res_flags_t            res,
  output logic signed [ENERGY_WIDTH-1:0] best_e,
  output logic [TAG_WIDTH-1:0]           best_tag,
  output logic signed [ENERGY_WIDTH-1:0] cur_e,
  output logic [aac_pkg::TEMP_W-1:0]     temperature
);
  import aac_pkg::*;

  localparam int IDX_W  = $clog2(EXP_TABLE_DEPTH);
  localparam int CNT_W  = $clog2(IDX_W + 1);
  localparam int NUM_W  = ENERGY_WIDTH + 4;
  localparam int DEN_W  = TEMP_W + IDX_W;
  localparam int SW     = ((NUM_W > DEN_W) ? NUM_W : DEN_W) + 1;
  localparam int PRD_W  = TEMP_W + COOL_W;
  localparam int ROM_AW = $clog2(EXP_MAX_DEPTH);

  localparam exp_rom_t EXP_ROM = build_exp_rom();

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_START = 4'd1;
  localparam logic [3:0] ST_CMP   = 4'd2;
  localparam logic [3:0] ST_DIV   = 4'd3;
  localparam logic [3:0] ST_LOOK  = 4'd4;
  localparam logic [3:0] ST_DEC   = 4'd5;
  localparam logic [3:0] ST_BEST  = 4'd6;
  localparam logic [3:0] ST_COOL  = 4'd7;
  localparam logic [3:0] ST_FCHK  = 4'd8;
  localparam logic [3:0] ST_FIN   = 4'd9;

  logic [3:0]              state;
  logic                    finished;
  logic                    acc;
  logic [TAG_WIDTH-1:0]    cur_tag;
  logic [TAG_WIDTH-1:0]    it_tag;
  logic [ENERGY_WIDTH-1:0] it_energy;
  logic [FRAC_W-1:0]       it_rnd;
  logic [SW-1:0]           num;
  logic [IDX_W-1:0]        quo;
  logic [CNT_W-1:0]        cnt;
  logic [PROB_W-1:0]       prob;

  logic [SW-1:0]           sub_a;
  logic [SW-1:0]           sub_b;
  logic [SW-1:0]           sub_diff;
  logic                    sub_borrow;
  logic [PRD_W-1:0]        cool_prod;

  // Operand selection for the shared subtractor.
  always_comb begin
    case (state)
      ST_CMP: begin
        sub_a = {{(SW-ENERGY_WIDTH){it_energy[ENERGY_WIDTH-1]}}, it_energy};
        sub_b = {{(SW-ENERGY_WIDTH){cur_e[ENERGY_WIDTH-1]}}, cur_e};
      end
      ST_DIV: begin
        sub_a = num;
        sub_b = SW'(temperature) << cnt;
      end
      ST_BEST: begin
        sub_a = {{(SW-ENERGY_WIDTH){it_energy[ENERGY_WIDTH-1]}}, it_energy};
        sub_b = {{(SW-ENERGY_WIDTH){best_e[ENERGY_WIDTH-1]}}, best_e};
      end
      ST_FCHK: begin
        sub_a = SW'(cfg.end_temp);
        sub_b = SW'(temperature);
      end
      default: begin
        sub_a = '0;
        sub_b = '0;
      end
    endcase
  end

  aac_sub #(
    .W(SW)
  ) u_sub (
    .a      (sub_a),
    .b      (sub_b),
    .diff   (sub_diff),
    .borrow (sub_borrow)
  );

  // Geometric cooling product, registered straight into the temperature.
  assign cool_prod = PRD_W'(temperature) * PRD_W'(cfg.cooling);

  // Sequencer and architectural state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      finished    <= 1'b1;
      acc         <= 1'b0;
      temperature <= '0;
      cur_e       <= '0;
      best_e      <= '0;
      cur_tag     <= '0;
      best_tag    <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (start) begin
            it_tag    <= tag;
            it_energy <= energy;
            it_rnd    <= rnd;
            acc       <= 1'b0;
            if (!kind) begin
              state <= ST_START;
            end else if (finished) begin
              state <= ST_FIN;
            end else begin
              state <= ST_CMP;
            end
          end
        end
        ST_START: begin
          cur_e       <= it_energy;
          best_e      <= it_energy;
          cur_tag     <= it_tag;
          best_tag    <= it_tag;
          temperature <= cfg.start_temp;
          state       <= ST_FCHK;
        end
        ST_CMP: begin
          // No rise in energy: accept at once. Else reject at zero temperature, or find floor(16*du/T).
          if (sub_diff[SW-1] || (sub_diff == '0)) begin
            acc   <= 1'b1;
            state <= ST_BEST;
          end else if (temperature == '0) begin
            state <= ST_COOL;
          end else begin
            num   <= SW'({sub_diff[ENERGY_WIDTH-1:0], 4'b0000});
            quo   <= '0;
            cnt   <= CNT_W'(IDX_W);
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (cnt == CNT_W'(IDX_W)) begin
            // Quotient would not fit the table index: probability is zero.
            if (!sub_borrow) begin
              state <= ST_COOL;
            end else begin
              cnt <= cnt - 1'b1;
            end
          end else begin
            if (!sub_borrow) begin
              num <= sub_diff;
              quo <= quo | (IDX_W'(1) << cnt);
            end
            if (cnt == '0) begin
              state <= ST_LOOK;
            end else begin
              cnt <= cnt - 1'b1;
            end
          end
        end
        ST_LOOK: begin
          if ({1'b0, quo} < (IDX_W + 1)'(EXP_TABLE_DEPTH)) begin
            prob <= EXP_ROM[ROM_AW'(quo)];
          end else begin
            prob <= '0;
          end
          state <= ST_DEC;
        end
        ST_DEC: begin
          if ({1'b0, it_rnd} < prob) begin
            acc   <= 1'b1;
            state <= ST_BEST;
          end else begin
            state <= ST_COOL;
          end
        end
        ST_BEST: begin
          cur_e   <= it_energy;
          cur_tag <= it_tag;
          if (sub_diff[SW-1]) begin
            best_e   <= it_energy;
            best_tag <= it_tag;
          end
          state <= ST_COOL;
        end
        ST_COOL: begin
          temperature <= cool_prod[PRD_W-1:COOL_W];
          state       <= ST_FCHK;
        end
        ST_FCHK: begin
          // Finished when the temperature is at or below the end temperature.
          finished <= !sub_borrow;
          state    <= ST_FIN;
        end
        ST_FIN: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign idle         = (state == ST_IDLE);
  assign res.load     = (state == ST_FIN) && out_free;
  assign res.accepted = acc;
  assign res.done     = finished;

endmodule
